// ===== rtl/core/fct_pkg.sv =====
// Package for the fan curve and tachometer block.
// Holds item kinds, register indexes, command/status structs and constants.
// No dependencies.
`default_nettype none

package fct_pkg;

	// Item kinds
	localparam logic [1:0] KIND_TEMP = 2'd0;
	localparam logic [1:0] KIND_TACH = 2'd1;
	localparam logic [1:0] KIND_RPM  = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_TEMP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_TEMP = 1'd1;

	// Reset values of the thresholds, 1/16 degree
	localparam logic signed [15:0] LOW_TEMP_RST  = 16'sd480;
	localparam logic signed [15:0] HIGH_TEMP_RST = 16'sd960;

	// Arithmetic constants
	localparam logic [6:0]  FULL_DUTY  = 7'd100;
	localparam logic [31:0] TACH_SCALE = 32'd30000000;
	localparam logic [31:0] RPM_MAX    = 32'hFFFF_FFFF;

	// Divider: 32 dividend bits, one per cycle
	localparam int unsigned DIV_W     = 32;
	localparam int unsigned DIV_CNT_W = 5;
	// TACH_SCALE < 2^25, so the rpm quotient fits in 25 bits
	localparam int unsigned QUO_W     = 25;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;      // capture the accepted item
		logic div_init;  // set up dividend/divisor
		logic div_step;  // one restoring divide step
		logic mul;       // quotient times edge count
		logic commit;    // update state, load result register
	} fct_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [1:0] kind;
		logic       div_needed;
	} fct_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/fct_item_if.sv =====
// Input item channel: valid/ready plus kind, temperature and time.
// Depends on nothing.
`default_nettype none

interface fct_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] temperature;
	logic [31:0]        now_us;

	modport source (output valid, output kind, output temperature, output now_us,
		input ready);
	modport sink (input valid, input kind, input temperature, input now_us,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fct_result_if.sv =====
// Result channel: valid/ready plus duty, change flag and rpm.
// Depends on nothing.
`default_nettype none

interface fct_result_if;
	logic        valid;
	logic        ready;
	logic [6:0]  duty_percent;
	logic        duty_changed;
	logic [31:0] rpm_value;

	modport source (output valid, output duty_percent, output duty_changed,
		output rpm_value, input ready);
	modport sink (input valid, input duty_percent, input duty_changed,
		input rpm_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fct_cfg_if.sv =====
// Configuration write channel: valid/ready plus register index and data.
// Depends on fct_pkg for the index width.
`default_nettype none

interface fct_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [fct_pkg::CFG_IDX_W-1:0]    index;
	logic [15:0]                      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fct_dp.sv =====
// Datapath: thresholds, fan state, tach state, shared restoring divider,
// rpm multiplier and the result register. Driven by fct_ctrl; uses fct_pkg.
`default_nettype none

module fct_dp (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire fct_pkg::fct_cmd_t          cmd,
	output fct_pkg::fct_sts_t               sts,
	input  wire                             cfg_we,
	input  wire [fct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [15:0]                      cfg_data,
	input  wire [1:0]                       kind,
	input  wire signed [15:0]               temperature,
	input  wire [31:0]                      now_us,
	output logic [6:0]                      duty_percent,
	output logic                            duty_changed,
	output logic [31:0]                     rpm_value
);

	logic signed [15:0] low_q, high_q;
	logic [6:0]         duty_q;
	logic [31:0]        count_q, last_q;

	logic [1:0]         kind_q;
	logic signed [15:0] temp_q;
	logic [31:0]        now_q;

	logic [fct_pkg::DIV_W-1:0] dvd_q, dsr_q, rem_q;
	logic [56:0]               prod_q;

	logic [6:0]  duty_out_q;
	logic        chg_out_q;
	logic [31:0] rpm_out_q;

	// Curve terms
	logic signed [16:0] diff, den;
	logic               at_low, at_high;
	logic [23:0]        num;
	logic [31:0]        elapsed;

	assign diff    = {temp_q[15], temp_q} - {low_q[15], low_q};
	assign den     = {high_q[15], high_q} - {low_q[15], low_q};
	assign at_low  = temp_q <= low_q;
	assign at_high = temp_q >= high_q;
	assign num     = {7'd0, diff[16:0]} * {17'd0, fct_pkg::FULL_DUTY};
	assign elapsed = now_q - last_q;

	assign sts.kind       = kind_q;
	assign sts.div_needed = ((kind_q == fct_pkg::KIND_TEMP) && !at_low && !at_high) ||
		((kind_q == fct_pkg::KIND_RPM) && (elapsed != 32'd0));

	// Divider step
	logic [fct_pkg::DIV_W:0]   shifted;
	logic                      take;
	logic [fct_pkg::DIV_W:0]   diff_rem;

	assign shifted  = {rem_q, dvd_q[fct_pkg::DIV_W-1]};
	assign take     = shifted >= {1'b0, dsr_q};
	assign diff_rem = shifted - {1'b0, dsr_q};

	// Result of the committed item
	logic [6:0]  duty_next;
	logic [31:0] rpm_next;

	always_comb begin
		duty_next = duty_q;
		rpm_next  = 32'd0;
		case (kind_q)
			fct_pkg::KIND_TEMP: begin
				if (at_low)
					duty_next = 7'd0;
				else if (at_high)
					duty_next = fct_pkg::FULL_DUTY;
				else
					duty_next = dvd_q[6:0];
			end
			fct_pkg::KIND_RPM: begin
				if (elapsed == 32'd0 || prod_q[56:32] != 25'd0)
					rpm_next = fct_pkg::RPM_MAX;
				else
					rpm_next = prod_q[31:0];
			end
			default: begin
				duty_next = duty_q;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= fct_pkg::LOW_TEMP_RST;
			high_q <= fct_pkg::HIGH_TEMP_RST;
		end else if (cfg_we) begin
			if (cfg_index == fct_pkg::REG_LOW_TEMP)
				low_q <= cfg_data;
			else if (cfg_index == fct_pkg::REG_HIGH_TEMP)
				high_q <= cfg_data;
		end
	end

	// Fan and tach state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q  <= 7'd0;
			count_q <= 32'd0;
			last_q  <= 32'd0;
		end else if (cmd.commit) begin
			case (kind_q)
				fct_pkg::KIND_TEMP: duty_q <= duty_next;
				fct_pkg::KIND_TACH: count_q <= count_q + 32'd1;
				fct_pkg::KIND_RPM: begin
					count_q <= 32'd0;
					last_q  <= now_q;
				end
				default: ;
			endcase
		end
	end

	// Item capture, divider, multiplier, result register (payload only)
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			temp_q <= temperature;
			now_q  <= now_us;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			if (kind_q == fct_pkg::KIND_RPM) begin
				dvd_q <= fct_pkg::TACH_SCALE;
				dsr_q <= elapsed;
			end else begin
				dvd_q <= {8'd0, num};
				dsr_q <= {15'd0, den[16:0]};
			end
		end else if (cmd.div_step) begin
			rem_q <= take ? diff_rem[fct_pkg::DIV_W-1:0] : shifted[fct_pkg::DIV_W-1:0];
			dvd_q <= {dvd_q[fct_pkg::DIV_W-2:0], take};
		end
		if (cmd.mul)
			prod_q <= dvd_q[fct_pkg::QUO_W-1:0] * count_q;
		if (cmd.commit) begin
			duty_out_q <= duty_next;
			chg_out_q  <= (kind_q == fct_pkg::KIND_TEMP) && (duty_next != duty_q);
			rpm_out_q  <= rpm_next;
		end
	end

	assign duty_percent = duty_out_q;
	assign duty_changed = chg_out_q;
	assign rpm_value    = rpm_out_q;

endmodule

`default_nettype wire

// ===== rtl/core/fct_ctrl.sv =====
// Controller: sequences capture, divide, multiply and commit for one item
// and owns the result valid flag. Uses fct_pkg command/status types.
`default_nettype none

module fct_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire                    out_ready,
	input  wire fct_pkg::fct_sts_t sts,
	output fct_pkg::fct_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic [fct_pkg::DIV_CNT_W-1:0] CNT_LAST = fct_pkg::DIV_CNT_W'(fct_pkg::DIV_W - 1);

	logic [2:0]                    state_q, state_d;
	logic [fct_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          out_valid_q;
	logic                          slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				if (sts.div_needed) begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST)
					state_d = (sts.kind == fct_pkg::KIND_RPM) ? ST_MUL : ST_FIN;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Checks
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_PREP)
		else $error("accepted item did not move to prep");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> slot_free)
		else $error("commit while result register still full");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not raise result valid");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && cnt_q == CNT_LAST |=> state_q != ST_DIV)
		else $error("divider ran past its last step");

endmodule

`default_nettype wire

// ===== rtl/core/fan_curve_and_tachometer_top.sv =====
// Top level of the fan curve and tachometer block.
// Depends on fct_pkg, fct_item_if, fct_result_if, fct_cfg_if, fct_ctrl, fct_dp.
//
//   channel    dir  content
//   item_in    in   kind, temperature, now_us
//   result_out out  duty_percent, duty_changed, rpm_value
//   cfg        in   index (0 low_temperature, 1 high_temperature), data
//
// A tach edge, an unused kind, a temperature at or past a threshold or an rpm read with
// zero elapsed time goes straight to commit; any other temperature uses the 32-step
// shared restoring divider, any other rpm read the divider and then the multiplier.
// One item in work at a time; the next is taken once its result is registered,
// even while that result is stalled. Reset clears control and state, thresholds to
// 480/960; config always ready, user to write it idle only, not enforced by the block.
`default_nettype none

module fan_curve_and_tachometer_top (
	input wire           clk,
	input wire           arst_n,
	fct_item_if.sink     item_in,
	fct_result_if.source result_out,
	fct_cfg_if.sink      cfg
);

	fct_pkg::fct_cmd_t cmd;
	fct_pkg::fct_sts_t sts;

	assign cfg.ready = 1'b1;

	fct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.in_ready  (item_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fct_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.kind         (item_in.kind),
		.temperature  (item_in.temperature),
		.now_us       (item_in.now_us),
		.duty_percent (result_out.duty_percent),
		.duty_changed (result_out.duty_changed),
		.rpm_value    (result_out.rpm_value)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the fan curve and tachometer block: a directed table,
// then random temperature, tach and rpm traffic under several threshold settings.
// Depends on fct_pkg, the three channel interfaces and fan_curve_and_tachometer_top.

module tb;

	localparam logic [1:0] KIND_UNUSED      = 2'd3;
	localparam int         SETTLE_CYCLES    = 40;
	localparam int         ITEMS_PER_SETTING = 84;
	localparam int         N_SETTINGS       = 6;
	localparam int         N_DIRECTED       = 27;
	localparam int         TIMEOUT_NS       = 2_000_000;

	typedef struct packed {
		logic [6:0]  duty;
		logic        changed;
		logic [31:0] rpm;
	} fan_result_t;

	// One row of the directed table; typed rows carry their own expected result
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] temp;
		logic [31:0] now;
		logic        typed;
		logic [6:0]  duty;
		logic        changed;
		logic [31:0] rpm;
		logic [7:0]  reps;
	} stim_row_t;

	// Thresholds 480/960 from reset; duty and edge count tracked by hand.
	// reps sends the row that many times in a row.
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{KIND_UNUSED, 16'h7FFF, 32'hFFFF_FFFF, 1'b1, 7'd0, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_TEMP, 16'h8000, 32'd0, 1'b1, 7'd0, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_TEMP, 16'h7FFF, 32'd0, 1'b1, 7'd100, 1'b1, 32'd0, 8'd1},
		'{fct_pkg::KIND_TEMP, 16'h7FFF, 32'd0, 1'b1, 7'd100, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_TEMP, 16'd480, 32'd0, 1'b1, 7'd0, 1'b1, 32'd0, 8'd1},
		'{fct_pkg::KIND_TEMP, 16'd481, 32'd0, 1'b0, 7'd0, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_TEMP, 16'd720, 32'd0, 1'b0, 7'd0, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_TEMP, 16'd959, 32'd0, 1'b0, 7'd0, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_TEMP, 16'd960, 32'd0, 1'b1, 7'd100, 1'b1, 32'd0, 8'd1},
		'{KIND_UNUSED, 16'h0000, 32'd0, 1'b1, 7'd100, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_RPM, 16'h0000, 32'd0, 1'b1, 7'd100, 1'b0, 32'hFFFF_FFFF, 8'd1},
		'{fct_pkg::KIND_TACH, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 7'd100, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_TACH, 16'h0000, 32'd0, 1'b1, 7'd100, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_RPM, 16'h0000, 32'd1000000, 1'b0, 7'd0, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_RPM, 16'h0000, 32'd1000000, 1'b1, 7'd100, 1'b0, 32'hFFFF_FFFF, 8'd1},
		'{fct_pkg::KIND_RPM, 16'h0000, 32'd1000001, 1'b0, 7'd0, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_RPM, 16'h0000, 32'hFFFF_FFFF, 1'b0, 7'd0, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_TACH, 16'h0000, 32'd0, 1'b1, 7'd100, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_RPM, 16'h0000, 32'h000F_423F, 1'b0, 7'd0, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_TACH, 16'h0000, 32'd0, 1'b1, 7'd100, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_RPM, 16'h0000, 32'h000F_4240, 1'b0, 7'd0, 1'b0, 32'd0, 8'd1},
		// largest edge count that still fits at one microsecond, then one more
		'{fct_pkg::KIND_TACH, 16'h0000, 32'd0, 1'b1, 7'd100, 1'b0, 32'd0, 8'd143},
		'{fct_pkg::KIND_RPM, 16'h0000, 32'h000F_4241, 1'b0, 7'd0, 1'b0, 32'd0, 8'd1},
		'{fct_pkg::KIND_TACH, 16'h0000, 32'd0, 1'b1, 7'd100, 1'b0, 32'd0, 8'd144},
		'{fct_pkg::KIND_RPM, 16'h0000, 32'h000F_4242, 1'b1, 7'd100, 1'b0, 32'hFFFF_FFFF, 8'd1},
		'{fct_pkg::KIND_TEMP, 16'h8000, 32'd0, 1'b1, 7'd0, 1'b1, 32'd0, 8'd1},
		'{fct_pkg::KIND_TEMP, 16'h0000, 32'd0, 1'b1, 7'd0, 1'b0, 32'd0, 8'd1}
	};

	logic clk = 1'b0;
	logic arst_n;

	fct_item_if   item_bus();
	fct_result_if result_bus();
	fct_cfg_if    cfg_bus();

	fan_curve_and_tachometer_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_bus),
		.result_out (result_bus),
		.cfg        (cfg_bus)
	);

	// Fan model state and thresholds
	logic signed [15:0] low_model  = fct_pkg::LOW_TEMP_RST;
	logic signed [15:0] high_model = fct_pkg::HIGH_TEMP_RST;
	logic [6:0]         duty_model = 7'd0;
	logic [31:0]        edge_model = 32'd0;
	logic [31:0]        last_time_model = 32'd0;

	fan_result_t expected_results [$];

	// Stimulus side bookkeeping
	logic        row_typed;
	fan_result_t row_exp;
	int          src_idle_pct = 32;
	int          snk_idle_pct = 47;
	logic [31:0] stim_last_now = 32'd0;
	int          cur_low  = 480;
	int          cur_high = 960;

	int n_fail = 0;
	int n_temp = 0;
	int n_changes = 0;
	int n_tach = 0;
	int n_read = 0;
	int n_sat = 0;
	int n_settings = 0;

	always #2 clk = ~clk;

	// Duty curve, edge counter and rpm meter for one item
	function automatic fan_result_t predict_fan(input logic [1:0] kind,
		input logic signed [15:0] temp, input logic [31:0] now);
		fan_result_t r;
		int          t;
		longint      num;
		longint      den;
		logic [6:0]  d;
		logic [31:0] elapsed;
		logic [63:0] prod;
		r = '0;
		case (kind)
			fct_pkg::KIND_TEMP: begin
				t = temp;
				if (t <= int'(low_model)) begin
					d = 7'd0;
				end else if (t >= int'(high_model)) begin
					d = fct_pkg::FULL_DUTY;
				end else begin
					num = (longint'(t) - longint'(low_model)) * 100;
					den = longint'(high_model) - longint'(low_model);
					d = 7'(num / den);
				end
				if (d != duty_model) begin
					duty_model = d;
					r.changed = 1'b1;
				end
			end
			fct_pkg::KIND_TACH: begin
				edge_model = edge_model + 32'd1;
			end
			fct_pkg::KIND_RPM: begin
				elapsed = now - last_time_model;
				if (elapsed == 32'd0) begin
					r.rpm = fct_pkg::RPM_MAX;
				end else begin
					prod = 64'(fct_pkg::TACH_SCALE / elapsed) * 64'(edge_model);
					r.rpm = (prod > 64'(fct_pkg::RPM_MAX)) ? fct_pkg::RPM_MAX : prod[31:0];
				end
				edge_model = 32'd0;
				last_time_model = now;
			end
			default: ;
		endcase
		r.duty = duty_model;
		return r;
	endfunction

	// Temperatures clustered around the current thresholds, some anywhere
	function automatic logic [15:0] pick_temperature();
		int lo;
		int hi;
		int v;
		int sel;
		lo = (cur_low < cur_high) ? cur_low : cur_high;
		hi = (cur_low < cur_high) ? cur_high : cur_low;
		sel = int'($urandom_range(9));
		if (sel < 2)
			v = int'($urandom_range(65535)) - 32768;
		else if (sel < 4)
			v = cur_low + int'($urandom_range(6)) - 3;
		else if (sel < 5)
			v = cur_high + int'($urandom_range(6)) - 3;
		else
			v = lo + int'($urandom_range(hi - lo));
		if (v < -32768)
			v = -32768;
		if (v > 32767)
			v = 32767;
		return v[15:0];
	endfunction

	// Read times: zero, tiny, typical, huge and wrapped intervals
	function automatic logic [31:0] pick_read_time();
		int unsigned sel;
		logic [31:0] t;
		sel = $urandom_range(9);
		case (sel)
			0: t = stim_last_now;
			1, 2: t = stim_last_now + $urandom_range(20, 1);
			3, 4, 5: t = stim_last_now + $urandom_range(2000000, 1000);
			6: t = stim_last_now + $urandom_range(40000000, 25000000);
			7: t = $urandom;
			8: t = $urandom_range(999);
			default: t = stim_last_now + $urandom_range(200, 1);
		endcase
		return t;
	endfunction

	// One item transfer, with random idle cycles in front
	task automatic send_item(input logic [1:0] kind, input logic [15:0] temp,
		input logic [31:0] now, input logic typed, input fan_result_t exp);
		while ($urandom_range(99) < src_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid       <= 1'b1;
		item_bus.kind        <= kind;
		item_bus.temperature <= temp;
		item_bus.now_us      <= now;
		row_typed            <= typed;
		row_exp              <= exp;
		do @(posedge clk); while (!item_bus.ready);
		if (kind == fct_pkg::KIND_RPM)
			stim_last_now = now;
	endtask

	task automatic write_reg(input logic [fct_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	// Drain the block, then load both thresholds
	task automatic apply_thresholds(input logic [15:0] lo, input logic [15:0] hi);
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(fct_pkg::REG_LOW_TEMP, lo);
		write_reg(fct_pkg::REG_HIGH_TEMP, hi);
		cfg_bus.valid <= 1'b0;
		cur_low  = $signed(lo);
		cur_high = $signed(hi);
		n_settings++;
	endtask

	// Mostly tach bursts closed by a read, and temperature samples; some noise
	task automatic run_random(input int count);
		int          left;
		int          sel;
		int          burst;
		logic [1:0]  k;
		left = count;
		while (left > 0) begin
			sel = int'($urandom_range(19));
			if (sel < 8) begin
				send_item(fct_pkg::KIND_TEMP, pick_temperature(), $urandom, 1'b0, '0);
				left--;
			end else if (sel < 15) begin
				burst = ($urandom_range(15) == 0) ? int'($urandom_range(220, 144))
					: int'($urandom_range(8));
				// keep the burst and its read inside this setting's budget
				if (burst > left - 1)
					burst = left - 1;
				repeat (burst)
					send_item(fct_pkg::KIND_TACH, 16'($urandom), $urandom, 1'b0, '0);
				send_item(fct_pkg::KIND_RPM, 16'($urandom), pick_read_time(), 1'b0, '0);
				left -= burst + 1;
			end else if (sel < 17) begin
				send_item(KIND_UNUSED, 16'($urandom), $urandom, 1'b0, '0);
			end else begin
				k = 2'($urandom);
				send_item(k, 16'($urandom), $urandom, 1'b0, '0);
				if (k != KIND_UNUSED)
					left--;
			end
		end
	endtask

	// Result sink with random stalls
	always @(posedge clk) begin
		result_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Track config writes and item transfers, check results
	always @(posedge clk) begin
		fan_result_t want;
		fan_result_t got;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					fct_pkg::REG_LOW_TEMP: low_model = cfg_bus.data;
					fct_pkg::REG_HIGH_TEMP: high_model = cfg_bus.data;
					default: ;
				endcase
			end
			if (item_bus.valid && item_bus.ready) begin
				want = predict_fan(item_bus.kind, item_bus.temperature, item_bus.now_us);
				if (row_typed)
					want = row_exp;
				expected_results.push_back(want);
				case (item_bus.kind)
					fct_pkg::KIND_TEMP: begin
						n_temp++;
						if (want.changed)
							n_changes++;
					end
					fct_pkg::KIND_TACH: n_tach++;
					fct_pkg::KIND_RPM: begin
						n_read++;
						if (want.rpm == fct_pkg::RPM_MAX)
							n_sat++;
					end
					default: ;
				endcase
			end
			if (result_bus.valid && result_bus.ready) begin
				got.duty    = result_bus.duty_percent;
				got.changed = result_bus.duty_changed;
				got.rpm     = result_bus.rpm_value;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, duty %0d changed %0d rpm %0d",
						$time, got.duty, got.changed, got.rpm);
					n_fail++;
				end else begin
					want = expected_results.pop_front();
					if (got.duty != want.duty) begin
						$display("%0t: duty_percent expected %0d, got %0d",
							$time, want.duty, got.duty);
						n_fail++;
					end
					if (got.changed != want.changed) begin
						$display("%0t: duty_changed expected %0d, got %0d",
							$time, want.changed, got.changed);
						n_fail++;
					end
					if (got.rpm != want.rpm) begin
						$display("%0t: rpm_value expected %0d, got %0d",
							$time, want.rpm, got.rpm);
						n_fail++;
					end
				end
			end
		end
	end

	// Main sequence: reset, directed table, random phases per idling pattern
	initial begin
		logic [15:0] lo_set [N_SETTINGS];
		logic [15:0] hi_set [N_SETTINGS];
		fan_result_t exp;
		arst_n               = 1'b0;
		item_bus.valid       = 1'b0;
		item_bus.kind        = fct_pkg::KIND_TEMP;
		item_bus.temperature = 16'd0;
		item_bus.now_us      = 32'd0;
		result_bus.ready     = 1'b0;
		cfg_bus.valid        = 1'b0;
		cfg_bus.index        = fct_pkg::REG_LOW_TEMP;
		cfg_bus.data         = 16'd0;
		row_typed            = 1'b0;
		row_exp              = '0;
		// reset value, full range, equal, inverted, narrowest, random
		lo_set[0] = 16'd480;  hi_set[0] = 16'd960;
		lo_set[1] = 16'h8000; hi_set[1] = 16'h7FFF;
		lo_set[2] = 16'd0;    hi_set[2] = 16'd0;
		lo_set[3] = 16'h7FFF; hi_set[3] = 16'h8000;
		lo_set[4] = 16'h8000; hi_set[4] = 16'h8001;
		lo_set[5] = 16'd0;    hi_set[5] = 16'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			exp.duty    = DIRECTED[i].duty;
			exp.changed = DIRECTED[i].changed;
			exp.rpm     = DIRECTED[i].rpm;
			for (int j = 0; j < int'(DIRECTED[i].reps); j++)
				send_item(DIRECTED[i].kind, DIRECTED[i].temp, DIRECTED[i].now,
					DIRECTED[i].typed, exp);
		end

		for (int mode = 0; mode < 3; mode++) begin
			src_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 47 : 0;
			snk_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 32 : 0;
			for (int s = 0; s < N_SETTINGS; s++) begin
				if (s == N_SETTINGS - 1)
					apply_thresholds(16'($urandom), 16'($urandom));
				else
					apply_thresholds(lo_set[s], hi_set[s]);
				run_random(ITEMS_PER_SETTING);
			end
		end

		// Drain and let the block settle
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d temperature samples (%0d duty changes), %0d tach edges,",
			n_temp, n_changes, n_tach);
		$display("%0d rpm reads (%0d saturated) over %0d threshold settings, 3 idle patterns.",
			n_read, n_sat, n_settings);
		if (n_fail == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule
